>>> hw/rtl/txwq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txwq_pkg: shared types and constants
// Request codes, status codes, widths and the front-to-back command record.
// ----------------------------------------------------------------------------
package txwq_pkg;
	localparam int QueueDepth = 64;
	localparam int PtrW = $clog2(QueueDepth);
	localparam int CntW = PtrW + 1;
	localparam int EntryW = 16 + 8 + 48 + 64;

	localparam logic [2:0] REQ_PUSH = 3'd0;
	localparam logic [2:0] REQ_PEEK = 3'd1;
	localparam logic [2:0] REQ_DISCARD = 3'd2;
	localparam logic [2:0] REQ_PURGE = 3'd3;
	localparam logic [2:0] REQ_CLEAR = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NULL = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// command handed from the front part to the back part
	typedef struct packed {
		logic [2:0] op;
		logic [1:0] status;
		logic [CntW-1:0] count;
		logic [7:0] path;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] done_count;
		logic entry_valid;
		logic [15:0] out_packet;
		logic [7:0] out_path;
		logic [47:0] out_destination;
		logic [63:0] out_time;
		logic last;
		logic [6:0] occupancy;
		logic [6:0] free_space;
	} result_t;
endpackage

>>> hw/rtl/txwq_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txwq_cmd_fifo: two-entry command queue
// Decouples the request front part from the storage back part.
// ----------------------------------------------------------------------------
module txwq_cmd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  txwq_pkg::cmd_t   wr_cmd,
	output logic             rd_valid,
	input  logic             rd_ready,
	output txwq_pkg::cmd_t   rd_cmd
);
	txwq_pkg::cmd_t slot_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic do_wr, do_rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_cmd = slot_q[rp_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) slot_q[wp_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) wp_q <= ~wp_q;
			if (do_rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("command queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !do_rd) |=> cnt_q == 2'd2)
		else $error("full queue lost an entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !do_rd)
		else $error("read from empty queue");
endmodule

>>> hw/rtl/txwq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txwq_front: request classifier and batch tracker
// Writes push elements into the ring, tracks the open batch and issues
// commands to the back part.
// ----------------------------------------------------------------------------
module txwq_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      req_type,
	input  logic                            batch_last,
	input  logic [15:0]                     packet_handle,
	input  logic                            group_first,
	input  logic [7:0]                      path_id,
	input  logic [6:0]                      amount,
	input  logic [txwq_pkg::CntW-1:0]       free_now,
	input  logic [txwq_pkg::PtrW-1:0]       tail_ptr,
	input  logic                            back_idle,
	output logic                            wr_en,
	output logic [txwq_pkg::PtrW-1:0]       wr_addr,
	output logic                            cmd_valid,
	input  logic                            cmd_ready,
	output txwq_pkg::cmd_t                  cmd
);
	logic open_q, ovf_q, null_q, grp_q;
	logic [txwq_pkg::PtrW-1:0] start_q;
	logic [txwq_pkg::CntW-1:0] adm_q;
	logic is_push, accept, admit, n_ovf, n_null, n_grp;
	logic [txwq_pkg::PtrW-1:0] start_n;
	logic [txwq_pkg::CntW-1:0] adm_cur, adm_n, n_fin;

	// a push element waits until the back part has committed earlier work,
	// since free space and tail are taken against the committed state
	assign is_push = req_type == txwq_pkg::REQ_PUSH;
	always_comb begin
		in_ready = 1'b1;
		cmd_valid = 1'b0;
		if (is_push) begin
			in_ready = back_idle && (!batch_last || cmd_ready);
			cmd_valid = in_valid && back_idle && batch_last;
		end else if (req_type <= txwq_pkg::REQ_CLEAR) begin
			in_ready = cmd_ready;
			cmd_valid = in_valid;
		end
	end
	assign accept = in_valid && in_ready;

	always_comb begin
		start_n = open_q ? start_q : tail_ptr;
		adm_cur = open_q ? adm_q : '0;
		admit = adm_cur < free_now;
		adm_n = adm_cur + (admit ? 1'b1 : 1'b0);
		n_ovf = (open_q && ovf_q) || !admit;
		n_null = (open_q && null_q) || (admit && packet_handle == 16'd0);
		n_grp = admit ? (group_first && packet_handle != 16'd0) : (open_q && grp_q);
		n_fin = adm_n;
		if (n_ovf && adm_n != '0 && n_grp) n_fin = adm_n - 1'b1;
	end

	assign wr_en = accept && is_push && admit;
	assign wr_addr = start_n + adm_cur[txwq_pkg::PtrW-1:0];

	always_comb begin
		cmd.op = req_type;
		cmd.path = path_id;
		cmd.status = txwq_pkg::ST_OK;
		cmd.count = amount[txwq_pkg::CntW-1:0];
		if (is_push) begin
			cmd.count = n_fin;
			if (n_fin != '0 && n_null) begin
				cmd.status = txwq_pkg::ST_NULL;
				cmd.count = '0;
			end
			cmd.path = {2'b0, start_n};
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_push) begin
			start_q <= start_n;
			adm_q <= adm_n;
			ovf_q <= n_ovf;
			null_q <= n_null;
			grp_q <= n_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) open_q <= 1'b0;
		else if (accept && req_type <= txwq_pkg::REQ_CLEAR)
			open_q <= is_push && !batch_last;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> adm_cur < free_now)
		else $error("element admitted beyond free space");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_push && batch_last) |-> cmd_valid && cmd_ready)
		else $error("batch end without command");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_push) |-> back_idle)
		else $error("push while back part busy");
endmodule

>>> hw/rtl/txwq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txwq_back: ring storage and command sequencer
// Holds the entry memory and pointers, runs peek and purge walks, and emits
// results through a one-deep output register.
// ----------------------------------------------------------------------------
module txwq_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [6:0]                    queue_limit,
	input  logic                          wr_en,
	input  logic [txwq_pkg::PtrW-1:0]     wr_addr,
	input  logic [txwq_pkg::EntryW-1:0]   wr_data,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  txwq_pkg::cmd_t                cmd,
	output logic [txwq_pkg::CntW-1:0]     free_now,
	output logic [txwq_pkg::PtrW-1:0]     tail_ptr,
	output logic                          idle,
	output logic                          out_valid,
	input  logic                          out_ready,
	output txwq_pkg::result_t             out_res
);
	localparam int PW = txwq_pkg::PtrW;
	localparam int CW = txwq_pkg::CntW;
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PEEK = 3'd1;
	localparam logic [2:0] S_PEEKO = 3'd2;
	localparam logic [2:0] S_PURGE = 3'd3;
	localparam logic [2:0] S_PURGEW = 3'd4;

	logic [txwq_pkg::EntryW-1:0] mem [txwq_pkg::QueueDepth];
	logic [txwq_pkg::EntryW-1:0] rdata_q;
	logic [2:0] state_q;
	logic [PW-1:0] head_q, tail_q, rd_q, wp_q, raddr;
	logic [CW-1:0] fill_q, n_q, k_q, rem_q;
	logic [7:0] victim_q;
	logic res_v_q;
	txwq_pkg::result_t res_q, res_n;
	logic emit, out_free, mwe;
	logic [PW-1:0] maddr;
	logic [txwq_pkg::EntryW-1:0] mdata;
	logic [CW-1:0] lim, fill_next;
	logic [PW-1:0] head_next, tail_next;

	assign lim = (queue_limit > 7'(txwq_pkg::QueueDepth)) ?
		CW'(txwq_pkg::QueueDepth) : queue_limit[CW-1:0];
	assign free_now = (lim > fill_q) ? lim - fill_q : '0;
	assign tail_ptr = tail_q;
	assign out_free = !res_v_q || out_ready;
	assign out_valid = res_v_q;
	assign out_res = res_q;
	assign idle = state_q == S_IDLE && !cmd_valid;
	assign cmd_ready = state_q == S_IDLE && out_free;

	// read address: peek and purge walk from rd_q
	assign raddr = rd_q;
	// load read data only on a read step so it holds while the output stalls
	always_ff @(posedge clk) begin
		if (state_q == S_PEEK || state_q == S_PURGE) rdata_q <= mem[raddr];
	end

	always_comb begin
		mwe = wr_en;
		maddr = wr_addr;
		mdata = wr_data;
		if (state_q == S_PURGEW && rdata_q[119:112] != victim_q) begin
			mwe = 1'b1;
			maddr = wp_q;
			mdata = rdata_q;
		end
	end
	always_ff @(posedge clk) if (mwe) mem[maddr] <= mdata;

	always_comb begin
		emit = 1'b0;
		head_next = head_q;
		tail_next = tail_q;
		fill_next = fill_q;
		res_n = '0;
		res_n.last = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid && out_free) begin
					emit = 1'b1;
					case (cmd.op)
						txwq_pkg::REQ_PUSH: begin
							res_n.status = cmd.status;
							res_n.done_count = 7'(cmd.count);
							if (cmd.count != '0) begin
								tail_next = cmd.path[PW-1:0] + cmd.count[PW-1:0];
								fill_next = fill_q + cmd.count;
							end
						end
						txwq_pkg::REQ_PEEK: begin
							emit = (cmd.count == '0) || (fill_q == '0);
						end
						txwq_pkg::REQ_DISCARD: begin
							if (cmd.count > fill_q) begin
								res_n.status = txwq_pkg::ST_RANGE;
							end else begin
								res_n.done_count = 7'(cmd.count);
								head_next = head_q + cmd.count[PW-1:0];
								fill_next = fill_q - cmd.count;
							end
						end
						txwq_pkg::REQ_PURGE: emit = fill_q == '0;
						txwq_pkg::REQ_CLEAR: begin
							res_n.done_count = 7'(fill_q);
							fill_next = '0;
						end
						default: emit = 1'b0;
					endcase
				end
			end
			S_PEEKO: begin
				if (out_free) begin
					emit = 1'b1;
					res_n.done_count = 7'(n_q);
					res_n.entry_valid = 1'b1;
					res_n.out_packet = rdata_q[135:120];
					res_n.out_path = rdata_q[119:112];
					res_n.out_destination = rdata_q[111:64];
					res_n.out_time = rdata_q[63:0];
					res_n.last = k_q + 1'b1 == n_q;
				end
			end
			S_PURGEW: begin
				if (k_q + 1'b1 == n_q && out_free) begin
					emit = 1'b1;
					res_n.done_count = 7'(rem_q + (rdata_q[119:112] == victim_q));
					fill_next = fill_q - rem_q - CW'(rdata_q[119:112] == victim_q);
					tail_next = wp_q + PW'(rdata_q[119:112] != victim_q);
				end
			end
			default: emit = 1'b0;
		endcase
		if (fill_next == '0) begin
			head_next = '0;
			tail_next = '0;
		end
		res_n.occupancy = 7'(fill_next);
		res_n.free_space = 7'((lim > fill_next) ? lim - fill_next : '0);
	end

	always_ff @(posedge clk) begin
		if (emit) res_q <= res_n;
		if (state_q == S_IDLE && cmd_valid) begin
			victim_q <= cmd.path;
			rd_q <= head_q;
			wp_q <= head_q;
			k_q <= '0;
			rem_q <= '0;
			n_q <= (cmd.op == txwq_pkg::REQ_PEEK && cmd.count < fill_q) ?
				cmd.count : fill_q;
		end else if (state_q == S_PEEK) begin
			rd_q <= rd_q + 1'b1;
		end else if (state_q == S_PEEKO && out_free) begin
			k_q <= k_q + 1'b1;
		end else if (state_q == S_PURGE) begin
			rd_q <= rd_q + 1'b1;
		end else if (state_q == S_PURGEW && (k_q + 1'b1 != n_q || out_free)) begin
			if (rdata_q[119:112] == victim_q) rem_q <= rem_q + 1'b1;
			else wp_q <= wp_q + 1'b1;
			k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (emit) res_v_q <= 1'b1;
			else if (out_ready) res_v_q <= 1'b0;
			if (emit || state_q == S_IDLE) begin
				head_q <= head_next;
				tail_q <= tail_next;
				fill_q <= fill_next;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && out_free && !emit) begin
						state_q <= (cmd.op == txwq_pkg::REQ_PEEK) ? S_PEEK : S_PURGE;
					end
				end
				S_PEEK: state_q <= S_PEEKO;
				S_PEEKO: if (out_free) state_q <= (k_q + 1'b1 == n_q) ? S_IDLE : S_PEEK;
				S_PURGE: state_q <= S_PURGEW;
				S_PURGEW: if (k_q + 1'b1 != n_q || out_free)
					state_q <= (k_q + 1'b1 == n_q) ? S_IDLE : S_PURGE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(txwq_pkg::QueueDepth))
		else $error("occupancy beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && !out_ready) |=> $stable(res_q))
		else $error("held result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (head_q == '0 && tail_q == '0))
		else $error("empty ring with nonzero pointers");
endmodule

>>> hw/rtl/tx_wait_ring_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tx_wait_ring_queue: transmit wait ring with batch push and path purge
// Ring FIFO of transmit entries with peek, discard, purge and clear.
// ----------------------------------------------------------------------------
// Usage: requests enter on s_axis (tdata: request fields, tlast: batch_last,
// tuser: group_first). Results leave on m_axis, tlast set on the final result
// of each request. queue_limit is written on the cfg channel while idle.
// Push elements are taken one per cycle when no earlier command is still in
// the back part; a new batch can start once the command of the batch before
// has left the command queue and been taken by the back part. Push, discard
// and clear results pass through the command queue and are then registered
// in the output register, after any wait behind earlier commands. Peek and
// purge walk the ring one entry at a time through the single memory read port.
// A two-entry command queue separates request intake from the ring; one
// output register holds a result while the receiver stalls, and the back part
// waits on it. Reset empties the queue and sets the limit to 64; the ring
// memory itself is not cleared.
// ----------------------------------------------------------------------------
module tx_wait_ring_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// req_type[2:0], packet_handle[18:3], path_id[26:19], destination[74:27],
	// enqueue_time[138:75], amount[145:139], zero fill to 152
	input  logic [151:0]  s_axis_tdata,
	input  logic          s_axis_tlast,
	// group_first[0]
	input  logic          s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// status[1:0], done_count[8:2], entry_valid[9], out_packet[25:10],
	// out_path[33:26], out_destination[81:34], out_time[145:82],
	// occupancy[152:146], free_space[159:153]
	output logic [159:0]  m_axis_tdata,
	output logic          m_axis_tlast,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [6:0]    cfg_data
);
	logic [6:0] limit_q;
	logic f_valid, f_ready, b_valid, b_ready, wr_en, idle;
	txwq_pkg::cmd_t f_cmd, b_cmd;
	txwq_pkg::result_t res;
	logic [txwq_pkg::CntW-1:0] free_now;
	logic [txwq_pkg::PtrW-1:0] tail, wr_addr;
	// track whether the command queue holds anything
	logic f_valid_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= 7'd64;
		else if (cfg_valid) limit_q <= cfg_data;
	end

	assign f_valid_q = b_valid;

	txwq_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.req_type(s_axis_tdata[2:0]), .batch_last(s_axis_tlast),
		.packet_handle(s_axis_tdata[18:3]), .group_first(s_axis_tuser),
		.path_id(s_axis_tdata[26:19]), .amount(s_axis_tdata[145:139]),
		.free_now(free_now), .tail_ptr(tail), .back_idle(idle && !f_valid_q),
		.wr_en(wr_en), .wr_addr(wr_addr),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	txwq_cmd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_cmd(f_cmd),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_cmd(b_cmd)
	);

	txwq_back u_back (
		.clk(clk), .arst_n(arst_n), .queue_limit(limit_q),
		.wr_en(wr_en), .wr_addr(wr_addr),
		.wr_data({s_axis_tdata[18:3], s_axis_tdata[26:19], s_axis_tdata[74:27],
			s_axis_tdata[138:75]}),
		.cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
		.free_now(free_now), .tail_ptr(tail), .idle(idle),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
	);

	assign m_axis_tlast = res.last;
	assign m_axis_tdata = {res.free_space, res.occupancy, res.out_time,
		res.out_destination, res.out_path, res.out_packet, res.entry_valid,
		res.done_count, res.status};
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for tx_wait_ring_queue
// Drives push batches, peek, discard, purge, clear and ignored requests into
// the stream port. A local copy of the ring predicts every result, and each
// result is checked field by field in arrival order. Runs directed cases,
// limit changes, back-pressure and random traffic with random idle bursts.
// ----------------------------------------------------------------------------
module tb;
	logic          clk;
	logic          arst_n;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [151:0]  s_axis_tdata;
	logic          s_axis_tlast;
	logic          s_axis_tuser;
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [159:0]  m_axis_tdata;
	logic          m_axis_tlast;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [6:0]    cfg_data;

	tx_wait_ring_queue DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// ring copy
	logic [15:0] ring_packet [txwq_pkg::QueueDepth];
	logic [7:0]  ring_path [txwq_pkg::QueueDepth];
	logic [47:0] ring_dest [txwq_pkg::QueueDepth];
	logic [63:0] ring_time [txwq_pkg::QueueDepth];
	int head, tail, fill, bstart, badm, limit;
	bit b_open, b_ovf, b_null, b_grp;

	txwq_pkg::result_t pending_results [$];
	int errors, n_requests, n_results, n_peeked, n_purged;
	bit idle_en;
	int hold_cycles;

	always #4 clk = ~clk;

	function automatic int room();
		int lim;
		lim = (limit > txwq_pkg::QueueDepth) ? txwq_pkg::QueueDepth : limit;
		return (lim > fill) ? lim - fill : 0;
	endfunction

	function automatic void add_result(logic [1:0] st, int done, bit valid, int idx, bit lst);
		txwq_pkg::result_t r;
		int i;
		i = idx % txwq_pkg::QueueDepth;
		r = '0;
		r.status = st;
		r.done_count = 7'(done);
		r.entry_valid = valid;
		if (valid) begin
			r.out_packet = ring_packet[i];
			r.out_path = ring_path[i];
			r.out_destination = ring_dest[i];
			r.out_time = ring_time[i];
		end
		r.last = lst;
		r.occupancy = 7'(fill);
		r.free_space = 7'(room());
		pending_results.push_back(r);
	endfunction

	// advance the ring copy by one accepted request
	function automatic void predict_queue(logic [2:0] op, bit blast, logic [15:0] handle,
			bit grp, logic [7:0] path, logic [47:0] dest, logic [63:0] stamp,
			logic [6:0] amount);
		int n, i, rd, wr, removed, orig;
		logic [1:0] st;
		if (op == txwq_pkg::REQ_PUSH) begin
			if (!b_open) begin
				b_open = 1; b_ovf = 0; b_null = 0; b_grp = 0;
				badm = 0; bstart = tail;
			end
			if (badm < room()) begin
				i = (bstart + badm) % txwq_pkg::QueueDepth;
				ring_packet[i] = handle; ring_path[i] = path;
				ring_dest[i] = dest; ring_time[i] = stamp;
				if (handle == 0) b_null = 1;
				b_grp = grp && handle != 0;
				badm++;
			end else
				b_ovf = 1;
			if (!blast) return;
			n = badm;
			if (b_ovf && n > 0 && b_grp) n--;
			st = txwq_pkg::ST_OK;
			i = 0;
			if (n > 0) begin
				if (b_null) st = txwq_pkg::ST_NULL;
				else begin
					tail = (bstart + n) % txwq_pkg::QueueDepth;
					fill += n;
					i = n;
				end
			end
			b_open = 0; badm = 0;
			add_result(st, i, 0, 0, 1);
			return;
		end
		if (op > txwq_pkg::REQ_CLEAR) return;
		b_open = 0; badm = 0;
		case (op)
			txwq_pkg::REQ_PEEK: begin
				n = (amount > fill) ? fill : amount;
				if (n == 0) add_result(txwq_pkg::ST_OK, 0, 0, 0, 1);
				for (i = 0; i < n; i++)
					add_result(txwq_pkg::ST_OK, n, 1, head + i, i + 1 == n);
				n_peeked += n;
			end
			txwq_pkg::REQ_DISCARD: begin
				if (amount > fill) add_result(txwq_pkg::ST_RANGE, 0, 0, 0, 1);
				else begin
					head = (head + amount) % txwq_pkg::QueueDepth;
					fill -= amount;
					if (fill == 0) begin head = 0; tail = 0; end
					add_result(txwq_pkg::ST_OK, amount, 0, 0, 1);
				end
			end
			txwq_pkg::REQ_PURGE: begin
				orig = fill; rd = head; wr = head; removed = 0;
				for (i = 0; i < orig; i++) begin
					if (ring_path[rd] == path) removed++;
					else begin
						ring_packet[wr] = ring_packet[rd]; ring_path[wr] = ring_path[rd];
						ring_dest[wr] = ring_dest[rd]; ring_time[wr] = ring_time[rd];
						wr = (wr + 1) % txwq_pkg::QueueDepth;
					end
					rd = (rd + 1) % txwq_pkg::QueueDepth;
				end
				fill = orig - removed;
				if (fill == 0) begin head = 0; tail = 0; end
				else tail = wr;
				n_purged += removed;
				add_result(txwq_pkg::ST_OK, removed, 0, 0, 1);
			end
			default: begin
				n = fill;
				fill = 0; head = 0; tail = 0;
				add_result(txwq_pkg::ST_OK, n, 0, 0, 1);
			end
		endcase
	endfunction

	// offer one request; called at a falling edge, returns at a falling edge
	task automatic send_request(logic [2:0] op, bit blast, logic [15:0] handle, bit grp,
			logic [7:0] path, logic [47:0] dest, logic [63:0] stamp, logic [6:0] amount);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			s_axis_tvalid = 0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = {6'd0, amount, stamp, dest, path, handle, op};
		s_axis_tlast = blast;
		s_axis_tuser = grp;
		s_axis_tvalid = 1;
		// look at ready while it is settled, well ahead of the rising edge
		#1;
		while (!s_axis_tready) begin
			@(negedge clk);
			#1;
		end
		@(posedge clk);
		predict_queue(op, blast, handle, grp, path, dest, stamp, amount);
		n_requests++;
		@(negedge clk);
		s_axis_tvalid = 0;
	endtask

	task automatic push_one(bit blast, logic [15:0] handle, bit grp, logic [7:0] path);
		send_request(txwq_pkg::REQ_PUSH, blast, handle, grp, path,
			48'({$urandom, $urandom}), {$urandom, $urandom}, 7'd0);
	endtask

	task automatic plain_request(logic [2:0] op, logic [7:0] path, logic [6:0] amount);
		send_request(op, 1'b0, 16'($urandom), 1'($urandom_range(0, 1)), path,
			48'({$urandom, $urandom}), {$urandom, $urandom}, amount);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(negedge clk);
		// a purge of a full ring may still be walking
		repeat (140) @(negedge clk);
	endtask

	task automatic write_limit(logic [6:0] value);
		wait_drained();
		cfg_data = value;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		limit = value;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		txwq_pkg::result_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
				errors++;
			end else begin
				e = pending_results.pop_front();
				check_field("status", 64'(e.status), 64'(m_axis_tdata[1:0]));
				check_field("done_count", 64'(e.done_count), 64'(m_axis_tdata[8:2]));
				check_field("entry_valid", 64'(e.entry_valid), 64'(m_axis_tdata[9]));
				check_field("out_packet", 64'(e.out_packet), 64'(m_axis_tdata[25:10]));
				check_field("out_path", 64'(e.out_path), 64'(m_axis_tdata[33:26]));
				check_field("out_destination", 64'(e.out_destination),
					64'(m_axis_tdata[81:34]));
				check_field("out_time", e.out_time, m_axis_tdata[145:82]);
				check_field("last", 64'(e.last), 64'(m_axis_tlast));
				check_field("occupancy", 64'(e.occupancy), 64'(m_axis_tdata[152:146]));
				check_field("free_space", 64'(e.free_space), 64'(m_axis_tdata[159:153]));
			end
		end
	end

	// receiver: random stall bursts, plus a long hold-off on request
	initial begin
		int stall;
		stall = 0;
		m_axis_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready = 0;
			end else if (stall > 0) begin
				stall--;
				m_axis_tready = 0;
			end else begin
				m_axis_tready = 1;
				if (idle_en && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 18);
			end
		end
	end

	task automatic test_directed();
		send_request(txwq_pkg::REQ_PUSH, 1'b1, 16'hFFFF, 1'b1, 8'hFF, '1, '1, 7'd0);
		send_request(txwq_pkg::REQ_PUSH, 1'b1, 16'h0001, 1'b0, 8'h00, '0, '0, 7'd0);
		plain_request(txwq_pkg::REQ_PEEK, 8'd0, 7'd0);
		plain_request(txwq_pkg::REQ_PEEK, 8'd0, 7'h7F);
		plain_request(txwq_pkg::REQ_DISCARD, 8'd0, 7'h7F);
		push_one(1'b0, 16'h0005, 1'b0, 8'h11);
		push_one(1'b1, 16'h0000, 1'b1, 8'h11);
		// drop an open batch with a non-push request
		push_one(1'b0, 16'h0007, 1'b0, 8'h22);
		plain_request(txwq_pkg::REQ_PEEK, 8'd0, 7'd1);
		plain_request(3'd5, 8'd0, 7'd0);
		plain_request(3'd6, 8'd0, 7'd0);
		plain_request(3'd7, 8'd0, 7'd0);
		plain_request(txwq_pkg::REQ_PURGE, 8'hFF, 7'd0);
		plain_request(txwq_pkg::REQ_CLEAR, 8'd0, 7'd0);
		plain_request(txwq_pkg::REQ_PEEK, 8'd0, 7'd1);
		plain_request(txwq_pkg::REQ_DISCARD, 8'd0, 7'd0);
	endtask

	task automatic test_limits();
		int k;
		write_limit(7'd3);
		// overflow with a group-first last admitted element: withdrawn
		for (k = 0; k < 5; k++)
			push_one(k == 4, 16'($urandom_range(1, 65535)), k == 2, 8'h05);
		write_limit(7'd1);
		plain_request(txwq_pkg::REQ_CLEAR, 8'd0, 7'd0);
		push_one(1'b0, 16'h1234, 1'b1, 8'h01);
		push_one(1'b1, 16'h4321, 1'b0, 8'h01);
		push_one(1'b0, 16'h0000, 1'b1, 8'h01);
		push_one(1'b1, 16'h0042, 1'b0, 8'h01);
		plain_request(txwq_pkg::REQ_CLEAR, 8'd0, 7'd0);
		write_limit(7'd64);
		push_one(1'b0, 16'h0101, 1'b0, 8'h02);
		write_limit(7'd0);
		push_one(1'b1, 16'h0102, 1'b0, 8'h02);
		plain_request(txwq_pkg::REQ_PEEK, 8'd0, 7'd4);
		write_limit(7'd127);
		for (k = 0; k < 66; k++)
			push_one(k == 65, 16'($urandom_range(1, 65535)), 1'b0, 8'(k % 4));
		plain_request(txwq_pkg::REQ_PEEK, 8'd0, 7'h7F);
		plain_request(txwq_pkg::REQ_PURGE, 8'h02, 7'd0);
		write_limit(7'($urandom_range(2, 63)));
	endtask

	task automatic test_backpressure();
		int k;
		write_limit(7'd64);
		hold_cycles = 400;
		for (k = 0; k < 30; k++) begin
			if (k % 5 == 4) plain_request(txwq_pkg::REQ_PEEK, 8'd0, 7'd3);
			else push_one(1'b1, 16'($urandom_range(1, 65535)), 1'b0,
				8'($urandom_range(0, 3)));
		end
		// hold the sender until everything has come back
		while (pending_results.size() != 0) @(negedge clk);
		plain_request(txwq_pkg::REQ_DISCARD, 8'd0, 7'd10);
	endtask

	task automatic random_batch();
		int len, k;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 6);
		for (k = 0; k < len; k++)
			send_request(txwq_pkg::REQ_PUSH, k == len - 1,
				($urandom_range(0, 40) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)),
				$urandom_range(0, 2) == 0,
				($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)),
				48'({$urandom, $urandom}), {$urandom, $urandom}, 7'($urandom));
	endtask

	task automatic test_random(int total);
		int pick;
		while (n_requests < total) begin
			if (n_requests > total - 50) idle_en = 0;
			pick = $urandom_range(0, 99);
			if (pick < 55) random_batch();
			else if (pick < 70)
				plain_request(txwq_pkg::REQ_PEEK, 8'd0, ($urandom_range(0, 7) == 0) ?
					7'($urandom) : 7'($urandom_range(0, 8)));
			else if (pick < 82)
				plain_request(txwq_pkg::REQ_DISCARD, 8'd0, ($urandom_range(0, 5) == 0) ?
					7'($urandom) : 7'($urandom_range(0, fill + 1)));
			else if (pick < 90)
				plain_request(txwq_pkg::REQ_PURGE, ($urandom_range(0, 7) == 0) ?
					8'($urandom) : 8'($urandom_range(0, 3)), 7'd0);
			else if (pick < 93) plain_request(txwq_pkg::REQ_CLEAR, 8'd0, 7'd0);
			else if (pick < 96)
				plain_request(3'($urandom_range(5, 7)), 8'($urandom), 7'($urandom));
			else begin
				// broken batch: cut short by a peek
				push_one(1'b0, 16'($urandom_range(1, 65535)), 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 3)));
				plain_request(txwq_pkg::REQ_PEEK, 8'd0, 7'd2);
			end
			if ($urandom_range(0, 60) == 0 && idle_en)
				write_limit(($urandom_range(0, 1) != 0) ?
					7'($urandom_range(1, 64)) : 7'($urandom));
		end
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tlast = 0;
		s_axis_tuser = 0;
		cfg_valid = 0;
		cfg_data = '0;
		hold_cycles = 0;
		idle_en = 1;
		errors = 0; n_requests = 0; n_results = 0; n_peeked = 0; n_purged = 0;
		head = 0; tail = 0; fill = 0; bstart = 0; badm = 0; limit = 64;
		b_open = 0; b_ovf = 0; b_null = 0; b_grp = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_limits();
		test_backpressure();
		test_random(350);
		wait_drained();
		$display("Covered %0d requests and %0d results (%0d entries peeked, %0d purged),",
			n_requests, n_results, n_peeked, n_purged);
		$display("across limits 0 to 127, back-pressure and broken batches.");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("Timeout with %0d results outstanding", pending_results.size());
		$display("Regression FAIL");
		$finish;
	end
endmodule
